// ===== src/fdpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdpd_pkg
// Shared types and constants for the flip-dot pixel pulse driver: frame
// layout, phase encoding and the index-to-driver-address table.
// ----------------------------------------------------------------------------
package fdpd_pkg;

    localparam int FRAME_BITS = 16;
    localparam int BC_W       = $clog2(FRAME_BITS);
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 5;
    localparam int NUM_IDX    = 28;

    // frame bit positions
    localparam int COL_LSB    = 11;
    localparam int ROW_LSB    = 1;
    localparam int BIT_DATA   = 8;
    localparam int BIT_EN_OFF = 9;
    localparam int BIT_EN_ON  = 10;

    // configuration register indexes
    localparam logic CFG_PULSE_TICKS  = 1'b0;
    localparam logic CFG_SETTLE_TICKS = 1'b1;

    localparam logic [CFG_W-1:0] TICKS_RESET = 16'd300;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_SHIFT_DATA = 5'b00010,
        PH_PULSE      = 5'b00100,
        PH_SHIFT_ZERO = 5'b01000,
        PH_SETTLE     = 5'b10000
    } phase_t;

    // driver address skips every code divisible by eight
    localparam logic [IDX_W-1:0] ADDR_CODE [NUM_IDX] = '{
        5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
        5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
        5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
        5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
    };

endpackage
`default_nettype wire

// ===== src/flip_dot_pixel_pulse_driver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flip_dot_pixel_pulse_driver
// Steps the shift-register and coil-enable pins of a flip-dot panel, one
// beat per tick or set-dot command, one result beat of pin levels per input.
// ----------------------------------------------------------------------------
// For every input beat, the sequencer state and the result register update
// at the edge that accepts the beat, and a new beat is taken in every cycle
// while the result register is empty or being drained. A set-dot command
// (kind 1) loads a 16-bit driver frame when the block is idle and both
// indexes are below 28; otherwise it is refused (accepted 0). Tick beats
// (kind 0) then shift the frame MSB first at two ticks per bit with latch
// low, hold drive_enable high for pulse_ticks results, shift sixteen zero
// bits and wait settle_ticks ticks before busy_res drops. Register value
// zero counts as one. Configuration writes apply at the next wait load.
module flip_dot_pixel_pulse_driver
    import fdpd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_kind,
    input  wire logic [IDX_W-1:0] s_col,
    input  wire logic [IDX_W-1:0] s_row,
    input  wire logic             s_dot_on,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_shift_clock,
    output logic                  m_shift_data,
    output logic                  m_latch,
    output logic                  m_drive_enable,
    output logic                  m_busy_res,
    output logic                  m_accepted
);

    logic [CFG_W-1:0]      pulse_ticks_reg;
    logic [CFG_W-1:0]      settle_ticks_reg;

    phase_t                phase_reg, phase_next;
    logic [FRAME_BITS-1:0] word_reg, word_next;
    logic [BC_W-1:0]       bit_count_reg, bit_count_next;
    logic                  half_reg, half_next;
    logic [CFG_W-1:0]      wait_reg, wait_next;
    logic                  data_reg, data_next;

    logic                  m_valid_reg;
    logic                  clk_out_reg, data_out_reg, latch_reg;
    logic                  enable_reg, busy_reg, accepted_reg;

    logic                  take;
    logic                  cmd_ok;
    logic                  accepted_next;
    logic                  shifting_next;
    logic [IDX_W-1:0]      col_idx, row_idx;
    logic [FRAME_BITS-1:0] frame;
    logic [CFG_W-1:0]      pulse_load, settle_load;
    logic                  shift_done;
    logic                  last_bit;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ticks_reg  <= TICKS_RESET;
            settle_ticks_reg <= TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PULSE_TICKS:  pulse_ticks_reg  <= cfg_wdata;
                CFG_SETTLE_TICKS: settle_ticks_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign pulse_load  = (pulse_ticks_reg == '0) ? CFG_W'(1) : pulse_ticks_reg;
    assign settle_load = (settle_ticks_reg == '0) ? CFG_W'(1) : settle_ticks_reg;

    // frame build
    assign cmd_ok  = (phase_reg == PH_IDLE) && (s_col < IDX_W'(NUM_IDX))
                     && (s_row < IDX_W'(NUM_IDX));
    assign col_idx = (s_col < IDX_W'(NUM_IDX)) ? s_col : '0;
    assign row_idx = (s_row < IDX_W'(NUM_IDX)) ? s_row : '0;

    always_comb begin
        frame = '0;
        frame[COL_LSB +: IDX_W] = ADDR_CODE[col_idx];
        frame[ROW_LSB +: IDX_W] = ADDR_CODE[row_idx];
        frame[BIT_DATA]         = s_dot_on;
        frame[BIT_EN_ON]        = s_dot_on;
        frame[BIT_EN_OFF]       = !s_dot_on;
    end

    assign last_bit = (bit_count_reg == BC_W'(FRAME_BITS - 1));

    // sequencer
    always_comb begin
        phase_next     = phase_reg;
        word_next      = word_reg;
        bit_count_next = bit_count_reg;
        half_next      = half_reg;
        wait_next      = wait_reg;
        data_next      = data_reg;
        accepted_next  = 1'b0;
        shift_done     = 1'b0;

        if (take) begin
            if (s_kind) begin
                if (cmd_ok) begin
                    word_next      = frame;
                    bit_count_next = '0;
                    half_next      = 1'b0;
                    phase_next     = PH_SHIFT_DATA;
                    accepted_next  = 1'b1;
                end
            end else begin
                // shared shift step for both shift phases
                if (phase_reg == PH_SHIFT_DATA || phase_reg == PH_SHIFT_ZERO) begin
                    if (!half_reg) begin
                        data_next = word_reg[FRAME_BITS-1];
                        half_next = 1'b1;
                    end else begin
                        word_next      = {word_reg[FRAME_BITS-2:0], 1'b0};
                        bit_count_next = last_bit ? '0 : bit_count_reg + BC_W'(1);
                        half_next      = 1'b0;
                        shift_done     = last_bit;
                    end
                end

                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_SHIFT_DATA: begin
                        if (shift_done) begin
                            phase_next = PH_PULSE;
                            wait_next  = pulse_load;
                        end
                    end
                    PH_PULSE: begin
                        wait_next = wait_reg - CFG_W'(1);
                        if (wait_next == '0) begin
                            phase_next     = PH_SHIFT_ZERO;
                            word_next      = '0;
                            bit_count_next = '0;
                            half_next      = 1'b0;
                        end
                    end
                    PH_SHIFT_ZERO: begin
                        if (shift_done) begin
                            phase_next = PH_SETTLE;
                            wait_next  = settle_load;
                        end
                    end
                    PH_SETTLE: begin
                        wait_next = wait_reg - CFG_W'(1);
                        if (wait_next == '0) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    assign shifting_next = (phase_next == PH_SHIFT_DATA) || (phase_next == PH_SHIFT_ZERO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            word_reg      <= '0;
            bit_count_reg <= '0;
            half_reg      <= 1'b0;
            wait_reg      <= '0;
            data_reg      <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            word_reg      <= word_next;
            bit_count_reg <= bit_count_next;
            half_reg      <= half_next;
            wait_reg      <= wait_next;
            data_reg      <= data_next;
        end
    end

    // result register: pin levels after the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            clk_out_reg  <= !(shifting_next && half_next);
            data_out_reg <= data_next;
            latch_reg    <= !(shifting_next && (bit_count_next != '0 || half_next));
            enable_reg   <= (phase_next == PH_PULSE);
            busy_reg     <= (phase_next != PH_IDLE);
            accepted_reg <= accepted_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_shift_clock  = clk_out_reg;
    assign m_shift_data   = data_out_reg;
    assign m_latch        = latch_reg;
    assign m_drive_enable = enable_reg;
    assign m_busy_res     = busy_reg;
    assign m_accepted     = accepted_reg;

`ifndef ASSERT_OFF
    a_busy_refuses: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_kind && phase_reg != PH_IDLE) |=> !m_accepted)
        else $error("command taken while busy");

    a_enable_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_enable) |-> m_busy_res)
        else $error("drive enable outside a dot sequence");

    a_count_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (bit_count_reg != '0) |-> (phase_reg == PH_SHIFT_DATA || phase_reg == PH_SHIFT_ZERO))
        else $error("bit count nonzero outside a shift phase");

    a_wait_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PULSE || phase_reg == PH_SETTLE) |-> (wait_reg != '0))
        else $error("wait counter zero in a timed phase");
`endif

endmodule
`default_nettype wire
